// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

  localparam logic CFG_MODULUS  = 1'b0;
  localparam logic CFG_EXPONENT = 1'b1;

  typedef enum logic [3:0] {
    UA_IDLE,
    UA_CHECK,
    UA_REDUCE,
    UA_RED_WAIT,
    UA_TEST,
    UA_MULT,
    UA_MUL_WAIT,
    UA_SQUARE,
    UA_SQ_WAIT,
    UA_LOOP,
    UA_OUT,
    UA_ZERO
  } uaddr_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_START,
    JC_MUL,
    JC_SMALL,
    JC_BIT0,
    JC_MORE,
    JC_ALWAYS
  } jcond_t;

  typedef enum logic [1:0] {
    AS_ONE,
    AS_ACC,
    AS_BASE
  } a_sel_t;

  typedef enum logic {
    BS_MSG,
    BS_BASE
  } b_sel_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_BASE,
    DS_ACC,
    DS_BASE_STEP
  } dst_t;

  typedef struct packed {
    jcond_t jcond;
    uaddr_t target;
    logic   mul_go;
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   load;
    logic   out_go;
    logic   clear;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic small_mod;
    logic mul_done;
    logic exp_bit0;
    logic more;
  } status_t;

  function automatic ctrl_word_t urom(uaddr_t addr);
    ctrl_word_t cw;
    cw = '0;
    cw.target = UA_IDLE;
    case (addr)
      UA_IDLE: begin
        cw.jcond = JC_START;
        cw.load  = 1'b1;
      end
      UA_CHECK: begin
        cw.jcond  = JC_SMALL;
        cw.target = UA_ZERO;
      end
      UA_REDUCE: begin
        cw.mul_go = 1'b1;
        cw.a_sel  = AS_ONE;
        cw.b_sel  = BS_MSG;
      end
      UA_RED_WAIT: begin
        cw.jcond = JC_MUL;
        cw.dst   = DS_BASE;
      end
      UA_TEST: begin
        cw.jcond  = JC_BIT0;
        cw.target = UA_SQUARE;
      end
      UA_MULT: begin
        cw.mul_go = 1'b1;
        cw.a_sel  = AS_ACC;
        cw.b_sel  = BS_BASE;
      end
      UA_MUL_WAIT: begin
        cw.jcond = JC_MUL;
        cw.dst   = DS_ACC;
      end
      UA_SQUARE: begin
        cw.mul_go = 1'b1;
        cw.a_sel  = AS_BASE;
        cw.b_sel  = BS_BASE;
      end
      UA_SQ_WAIT: begin
        cw.jcond = JC_MUL;
        cw.dst   = DS_BASE_STEP;
      end
      UA_LOOP: begin
        cw.jcond  = JC_MORE;
        cw.target = UA_TEST;
      end
      UA_OUT: begin
        cw.jcond  = JC_ALWAYS;
        cw.out_go = 1'b1;
      end
      UA_ZERO: begin
        cw.jcond  = JC_ALWAYS;
        cw.out_go = 1'b1;
        cw.clear  = 1'b1;
      end
      default: begin
        cw.jcond = JC_ALWAYS;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/mexp_mulmod.sv =====
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] r
);

  localparam int CW = $clog2(W) + 1;

  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) begin
      s = s - {1'b0, md};
    end
    return s[W-1:0];
  endfunction

  always_comb begin
    r_nxt = add_mod(r_r, r_r, m_r);
    if (b_r[W-1]) begin
      r_nxt = add_mod(r_nxt, a_r, m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
        r_r   <= '0;
        a_r   <= a;
        b_r   <= b;
        m_r   <= m;
      end else if (run_r) begin
        r_r   <= r_nxt;
        b_r   <= {b_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign r    = r_r;

endmodule

// ===== rtl/mexp_seq.sv =====
module mexp_seq
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  status_t    st,
  output ctrl_word_t cw,
  output logic       busy
);

  uaddr_t upc_r, upc_nxt;
  uaddr_t upc_inc;
  logic   take;

  assign cw      = urom(upc_r);
  assign upc_inc = uaddr_t'(upc_r + 4'd1);

  always_comb begin
    case (cw.jcond)
      JC_NEXT:   take = 1'b0;
      JC_START:  take = 1'b0;
      JC_MUL:    take = 1'b0;
      JC_SMALL:  take = st.small_mod;
      JC_BIT0:   take = !st.exp_bit0;
      JC_MORE:   take = st.more;
      JC_ALWAYS: take = 1'b1;
      default:   take = 1'b1;
    endcase
  end

  always_comb begin
    upc_nxt = upc_inc;
    if (take) begin
      upc_nxt = cw.target;
    end else if (cw.jcond == JC_START && !st.start) begin
      upc_nxt = upc_r;
    end else if (cw.jcond == JC_MUL && !st.mul_done) begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != UA_IDLE);

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Channel  Ports                              Handshake
// input    start, in_message, busy            taken when start is high and busy is low
// result   out_valid, out_power_mod           one-cycle strobe, no back-pressure
// config   cfg_we, cfg_index, cfg_wdata       written on any edge with cfg_we high
// One word runs from acceptance to its result through the shared bit-serial multiplier, which
// forms every product; each clear exponent bit skips the multiply step and so shortens the word.
// A word with a modulus below two goes from the check state to the zero state, which strobes a zero result.
// Reset is synchronous and active low and restores the default modulus and exponent.
// The result is strobed for one cycle; the receiver cannot stall it.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] in_message,
  output logic        busy,
  output logic        out_valid,
  output logic [31:0] out_power_mod,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  modulus_r;
  logic [W-1:0]  exponent_r;
  logic [W-1:0]  msg_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  base_r;
  logic [W-1:0]  exp_sh_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic [31:0]   out_pm_r;

  ctrl_word_t    cw;
  status_t       st;
  logic          seq_busy;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic [W-1:0]  mul_r;
  logic          mul_done;

  always_comb begin
    st.start     = start;
    st.small_mod = (modulus_r[W-1:1] == '0);
    st.mul_done  = mul_done;
    st.exp_bit0  = exp_sh_r[0];
    st.more      = (cnt_r != '0);
  end

  mexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw),
    .busy  (seq_busy)
  );

  always_comb begin
    case (cw.a_sel)
      AS_ONE:  mul_a = W'(1);
      AS_ACC:  mul_a = acc_r;
      AS_BASE: mul_a = base_r;
      default: mul_a = base_r;
    endcase
    case (cw.b_sel)
      BS_MSG:  mul_b = msg_r;
      BS_BASE: mul_b = base_r;
      default: mul_b = base_r;
    endcase
  end

  mexp_mulmod #(
    .W (W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cw.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus_r),
    .done  (mul_done),
    .r     (mul_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= W'(32'd187);
      exponent_r  <= W'(32'd7);
      acc_r       <= '0;
      base_r      <= '0;
      exp_sh_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS:  modulus_r  <= W'(cfg_wdata);
          CFG_EXPONENT: exponent_r <= W'(cfg_wdata);
          default:      modulus_r  <= modulus_r;
        endcase
      end
      out_valid_r <= cw.out_go;
      if (cw.out_go) begin
        out_pm_r <= cw.clear ? 32'd0 : 32'(acc_r);
      end
      if (cw.load && start) begin
        msg_r    <= W'(in_message);
        acc_r    <= W'(1);
        exp_sh_r <= exponent_r;
        cnt_r    <= CW'(W);
      end
      if (cw.clear) begin
        acc_r    <= '0;
        base_r   <= '0;
        exp_sh_r <= '0;
        cnt_r    <= '0;
      end
      if (mul_done) begin
        case (cw.dst)
          DS_NONE: begin
            acc_r <= acc_r;
          end
          DS_BASE: begin
            base_r <= mul_r;
          end
          DS_ACC: begin
            acc_r <= mul_r;
          end
          DS_BASE_STEP: begin
            base_r   <= mul_r;
            exp_sh_r <= exp_sh_r >> 1;
            cnt_r    <= cnt_r - 1'b1;
          end
          default: begin
            acc_r <= acc_r;
          end
        endcase
      end
    end
  end

  assign busy          = seq_busy;
  assign out_valid     = out_valid_r;
  assign out_power_mod = out_pm_r;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 2400;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic [31:0] in_message;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_power_mod;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  logic [31:0] modulus_now;
  logic [31:0] exponent_now;
  logic [31:0] power_q[$];
  int unsigned mismatches;
  int unsigned stalled_cycles;

  modular_exponentiation DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_message   (in_message),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_power_mod(out_power_mod),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Right-to-left square-and-multiply with a reduction after every product.
  function automatic logic [31:0] predict_power_mod(logic [31:0] msg, logic [31:0] m,
                                                    logic [31:0] e);
    logic [63:0] acc;
    logic [63:0] base;
    logic [63:0] mm;
    if (m < 32'd2) begin
      return 32'd0;
    end
    mm = {32'd0, m};
    acc = 64'd1;
    base = {32'd0, msg} % mm;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) begin
        acc = (acc * base) % mm;
      end
      base = (base * base) % mm;
    end
    return acc[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_power_mod);
        mismatches++;
      end else begin
        want = power_q.pop_front();
        if (want !== out_power_mod) begin
          $display("%0t: power_mod mismatch, expected %h, actual %h",
                   $time, want, out_power_mod);
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      power_q.push_back(predict_power_mod(in_message, modulus_now, exponent_now));
    end
    if (rst_n && ((start && !busy) || out_valid)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_MODULUS) begin
      modulus_now = value;
    end else begin
      exponent_now = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] msg);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_message <= msg;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (power_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic test_default_key();
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd186);
    send_word(32'd187);
    send_word(32'd188);
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_key_extremes();
    wait_all_done();
    write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
    write_reg(CFG_EXPONENT, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFF);
    send_word(32'd2);
    send_word(32'd0);
    wait_all_done();
    write_reg(CFG_MODULUS, 32'd2);
    write_reg(CFG_EXPONENT, 32'd1);
    send_word(32'd3);
    send_word(32'hFFFF_FFFE);
    wait_all_done();
    write_reg(CFG_MODULUS, 32'h8000_0000);
    write_reg(CFG_EXPONENT, 32'h8000_0000);
    send_word(32'd3);
  endtask

  // Zero exponent, and moduli of one and zero, which leave nothing to reduce by.
  task automatic test_degenerate_keys();
    wait_all_done();
    write_reg(CFG_MODULUS, 32'd1000);
    write_reg(CFG_EXPONENT, 32'd0);
    send_word(32'd0);
    send_word(32'd5);
    wait_all_done();
    write_reg(CFG_EXPONENT, 32'd3);
    write_reg(CFG_MODULUS, 32'd1);
    send_word(32'd5);
    wait_all_done();
    write_reg(CFG_MODULUS, 32'd0);
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_random_keys();
    logic [31:0] m;
    logic [31:0] e;
    logic [31:0] msg;
    for (int p = 0; p < 6; p++) begin
      wait_all_done();
      case (p)
        0: begin
          m = 32'hFFFF_FFFF;
          e = $urandom();
        end
        1: begin
          m = $urandom_range(2, 15);
          e = 32'hFFFF_FFFF;
        end
        2: begin
          m = $urandom() | 32'h8000_0000;
          e = 32'd1;
        end
        3: begin
          m = $urandom_range(2, 65535);
          e = $urandom_range(1, 15);
        end
        4: begin
          m = 32'h8000_0001;
          e = $urandom();
        end
        default: begin
          m = $urandom();
          e = $urandom();
        end
      endcase
      if (m < 32'd2) begin
        m = 32'd2;
      end
      write_reg(CFG_MODULUS, m);
      write_reg(CFG_EXPONENT, e);
      repeat (45) begin
        if ($urandom_range(0, 7) == 0) begin
          wait_all_done();
        end
        case ($urandom_range(0, 3))
          0: msg = $urandom();
          1: msg = $urandom() % m;
          2: msg = m - 32'd1 - ($urandom() & 32'd3);
          default: msg = m + ($urandom() & 32'd3);
        endcase
        send_word(msg);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_message = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODULUS;
    cfg_wdata = '0;
    modulus_now = 32'd187;
    exponent_now = 32'd7;
    mismatches = 0;
    stalled_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_key();
    test_key_extremes();
    test_degenerate_keys();
    test_random_keys();

    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
